// ----- hw/rtl/mktdp_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mktdp_pkg
// Shared widths, reset values and cell control type for the trade-count DP.
// ----------------------------------------------------------------------------
package mktdp_pkg;

  localparam int PRICE_W  = 16;
  localparam int PROFIT_W = 32;
  localparam int TRADES_W = 5;
  localparam int SUM_W    = PROFIT_W + 2;

  localparam logic [TRADES_W-1:0] TRADES_RESET = 5'd2;

  typedef struct packed {
    logic en;
    logic clear;
  } cell_ctrl_t;

endpackage

// ----- hw/rtl/mktdp_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mktdp_if
// Valid/ready channels for price words in and profit words out.
// ----------------------------------------------------------------------------
interface mktdp_price_if;
  logic                          valid;
  logic                          ready;
  logic [mktdp_pkg::PRICE_W-1:0] price;
  logic                          first;

  modport source (output valid, output price, output first, input ready);
  modport sink   (input valid, input price, input first, output ready);
endinterface

interface mktdp_profit_if;
  logic                           valid;
  logic                           ready;
  logic [mktdp_pkg::PROFIT_W-1:0] best_profit;
  logic                           saturated;

  modport source (output valid, output best_profit, output saturated, input ready);
  modport sink   (input valid, input best_profit, input saturated, output ready);
endinterface

// ----- hw/rtl/mktdp_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mktdp_cell
// One trade count: holds best-ending-today and best-overall, updates them from
// the left neighbor's best-overall and the broadcast price move.
// ----------------------------------------------------------------------------
module mktdp_cell #(
  parameter int PRICE_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  mktdp_pkg::cell_ctrl_t          ctrl,
  input  logic [PRICE_BITS-1:0]          gain,
  input  logic signed [PRICE_BITS:0]     diff,
  input  logic [mktdp_pkg::PROFIT_W-1:0] left_best,
  output logic [mktdp_pkg::PROFIT_W-1:0] best,
  output logic                           clamp
);
  import mktdp_pkg::*;

  logic [PROFIT_W-1:0]     ending;
  logic [PROFIT_W-1:0]     ending_next;
  logic [PROFIT_W-1:0]     best_next;
  logic signed [SUM_W-1:0] fresh;
  logic signed [SUM_W-1:0] carry;
  logic signed [SUM_W-1:0] pick;

  always_comb begin
    fresh = $signed({2'b00, left_best}) + $signed({{(SUM_W-PRICE_BITS){1'b0}}, gain});
    carry = $signed({2'b00, ending}) + $signed({{(SUM_W-PRICE_BITS-1){diff[PRICE_BITS]}}, diff});
    pick  = (fresh > carry) ? fresh : carry;
    clamp = |pick[SUM_W-2:PROFIT_W];
    ending_next = clamp ? {PROFIT_W{1'b1}} : pick[PROFIT_W-1:0];
    best_next   = (ending_next > best) ? ending_next : best;
  end

  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      ending <= '0;
      best   <= '0;
    end else if (ctrl.en) begin
      ending <= ending_next;
      best   <= best_next;
    end
  end

endmodule

// ----- hw/rtl/max_profit_k_trades_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// max_profit_k_trades_dp
// Best stock profit with at most max_trades buy-sell transactions, per price.
// ----------------------------------------------------------------------------
// Usage:
//   prices  : valid/ready channel of price words; first=1 starts a new series,
//             clears all trade tables and yields a profit of 0.
//   profits : one word per accepted price, best_profit and a sticky saturated
//             flag that marks a clamped table entry anywhere in the series.
//   cfg_we / cfg_data : write max_trades (0..16, larger acts as MAX_TRADES)
//             while the block is idle.
// A row of MAX_TRADES cells, one per trade count, updates in the cycle the
// price is accepted; each cell reads its left neighbor's old best-overall.
// The selected count is registered into the output word once the output
// is free, and one price per cycle is sustained while the receiver takes words.
// When the receiver stalls, the output word holds and one more price is
// taken into the cells; further prices wait until the output drains.
// Reset (rst, synchronous) clears all tables, the previous price, the flag and
// both channels, and sets max_trades to 2.
// ----------------------------------------------------------------------------
module max_profit_k_trades_dp #(
  parameter int MAX_TRADES = 16,
  parameter int PRICE_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [mktdp_pkg::TRADES_W-1:0] cfg_data,
  mktdp_price_if.sink                    prices,
  mktdp_profit_if.source                 profits
);
  import mktdp_pkg::*;

  localparam int SEL_W = $clog2(MAX_TRADES + 1);

  logic [TRADES_W-1:0]   max_trades;
  logic [PRICE_BITS-1:0] prev_price;
  logic [PRICE_BITS-1:0] cur_price;
  logic                  clamp_seen;
  logic                  pend;
  logic                  out_valid;
  logic [PROFIT_W-1:0]   best_profit;
  logic                  saturated;

  logic                     accept;
  logic                     load_out;
  cell_ctrl_t               ctrl;
  logic signed [PRICE_BITS:0] diff;
  logic [PRICE_BITS-1:0]    gain;
  logic [SEL_W-1:0]         sel;
  logic [PROFIT_W-1:0]      best [0:MAX_TRADES];
  logic [MAX_TRADES-1:0]    cell_clamp;

  generate
    if (PRICE_BITS <= PRICE_W) begin : g_narrow
      assign cur_price = prices.price[PRICE_BITS-1:0];
    end else begin : g_wide
      assign cur_price = {{(PRICE_BITS-PRICE_W){1'b0}}, prices.price};
    end
  endgenerate

  assign load_out     = pend && (!out_valid || profits.ready);
  assign prices.ready = !pend || load_out;
  assign accept       = prices.valid && prices.ready;

  always_comb begin
    ctrl.clear = accept && prices.first;
    ctrl.en    = accept && !prices.first;
    diff = $signed({1'b0, cur_price}) - $signed({1'b0, prev_price});
    gain = diff[PRICE_BITS] ? '0 : diff[PRICE_BITS-1:0];
    sel  = ({{(32-TRADES_W){1'b0}}, max_trades} > 32'(MAX_TRADES)) ?
           SEL_W'(MAX_TRADES) : SEL_W'(max_trades);
  end

  assign best[0] = '0;

  generate
    for (genvar j = 1; j <= MAX_TRADES; j++) begin : g_cell
      mktdp_cell #(.PRICE_BITS(PRICE_BITS)) u_cell (
        .clk       (clk),
        .rst       (rst),
        .ctrl      (ctrl),
        .gain      (gain),
        .diff      (diff),
        .left_best (best[j-1]),
        .best      (best[j]),
        .clamp     (cell_clamp[j-1])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      max_trades <= TRADES_RESET;
    end else if (cfg_we) begin
      max_trades <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_price <= '0;
      clamp_seen <= 1'b0;
    end else if (ctrl.clear) begin
      prev_price <= cur_price;
      clamp_seen <= 1'b0;
    end else if (ctrl.en) begin
      prev_price <= cur_price;
      clamp_seen <= clamp_seen || (|cell_clamp);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      pend <= accept || (pend && !load_out);
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (profits.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      best_profit <= best[sel];
      saturated   <= clamp_seen;
    end
  end

  assign profits.valid       = out_valid;
  assign profits.best_profit = best_profit;
  assign profits.saturated   = saturated;

endmodule

// ----- hw/rtl/mktdp_check.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mktdp_check
// Port-level checks on the price and profit channels, bound to the top level.
// ----------------------------------------------------------------------------
module mktdp_check (
  input logic                           clk,
  input logic                           rst,
  input logic                           in_valid,
  input logic                           in_ready,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [mktdp_pkg::PROFIT_W-1:0] out_best,
  input logic                           out_sat
);
  import mktdp_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_best) && $stable(out_sat))
    else $error("profit word changed while stalled");

  a_reset_idle: assert property (@(posedge clk)
    $past(rst) |-> in_ready && !out_valid)
    else $error("channels not idle after reset");

  a_word_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && in_ready, 2))
    else $error("profit word without a matching price");

  a_one_buffered: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready && $past(out_valid && !out_ready) &&
    $past(in_valid && in_ready) |-> !in_ready)
    else $error("more than one price taken during stall");

endmodule

bind max_profit_k_trades_dp mktdp_check u_mktdp_check (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (prices.valid),
  .in_ready  (prices.ready),
  .out_valid (profits.valid),
  .out_ready (profits.ready),
  .out_best  (profits.best_profit),
  .out_sat   (profits.saturated)
);

// ----- tb/max_profit_k_trades_dp_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// max_profit_k_trades_dp_tb
// Drives price series through the block under random sender gaps and
// receiver stalls, and checks every profit word against a trade-table
// predictor or the listed profit of a typed directed row. A directed table
// goes first, followed by random phases, each under its own max_trades setting.
// ----------------------------------------------------------------------------
module max_profit_k_trades_dp_tb;
  import mktdp_pkg::*;

  localparam int     MAX_TRADES  = 16;
  localparam int     PHASES      = 12;
  localparam int     PHASE_WORDS = 128;
  localparam int     CYCLE_LIMIT = 200000;
  localparam longint PROFIT_TOP  = 64'h0000_0000_FFFF_FFFF;

  typedef struct packed {
    logic [PROFIT_W-1:0] best_profit;
    logic                saturated;
  } profit_word_t;

  typedef enum logic {ROW_PRICE, ROW_TRADES} row_kind_t;

  typedef struct packed {
    row_kind_t           kind;
    logic [TRADES_W-1:0] trades;
    logic [PRICE_W-1:0]  price;
    logic                first;
    logic                typed;
    logic [PROFIT_W-1:0] profit;
  } stim_row_t;

  typedef enum int {WALK_SMALL, SWING_EXTREME, ANY_PRICE, EDGE_BAND} price_style_t;
  typedef enum int {READY_ALWAYS, READY_HALF, READY_SPARSE} stall_mode_t;

  logic                clk;
  logic                rst;
  logic                cfg_we;
  logic [TRADES_W-1:0] cfg_data;

  mktdp_price_if  prices ();
  mktdp_profit_if profits ();

  max_profit_k_trades_dp #(
    .MAX_TRADES(MAX_TRADES),
    .PRICE_BITS(PRICE_W)
  ) uut (
    .clk     (clk),
    .rst     (rst),
    .cfg_we  (cfg_we),
    .cfg_data(cfg_data),
    .prices  (prices),
    .profits (profits)
  );

  // Trade-table predictor state
  logic [PROFIT_W-1:0] overall_best [0:MAX_TRADES] = '{default: '0};
  logic [PROFIT_W-1:0] ending_best  [0:MAX_TRADES] = '{default: '0};
  logic [PRICE_W-1:0]  last_seen_price = '0;
  logic                clamp_flag      = 1'b0;
  logic [TRADES_W-1:0] trades_setting  = TRADES_RESET;

  profit_word_t expected_profits [$];
  int           mismatches  = 0;
  int           cycle_count = 0;
  int           burst_left  = 0;
  int           stall_left  = 0;
  stall_mode_t  stall_mode  = READY_ALWAYS;

  stim_row_t directed_rows [0:25] = '{
    '{ROW_PRICE,  5'd0,  16'd100,   1'b0, 1'b1, 32'd100},
    '{ROW_PRICE,  5'd0,  16'hFFFF,  1'b1, 1'b1, 32'd0},
    '{ROW_PRICE,  5'd0,  16'h0000,  1'b0, 1'b0, 32'd0},
    '{ROW_PRICE,  5'd0,  16'hFFFF,  1'b0, 1'b1, 32'd65535},
    '{ROW_PRICE,  5'd0,  16'h0000,  1'b0, 1'b0, 32'd0},
    '{ROW_PRICE,  5'd0,  16'hFFFF,  1'b0, 1'b1, 32'd131070},
    '{ROW_PRICE,  5'd0,  16'h0000,  1'b0, 1'b0, 32'd0},
    '{ROW_PRICE,  5'd0,  16'hFFFF,  1'b0, 1'b1, 32'd131070},
    '{ROW_TRADES, 5'd0,  16'h0000,  1'b0, 1'b0, 32'd0},
    '{ROW_PRICE,  5'd0,  16'hFFFF,  1'b0, 1'b1, 32'd0},
    '{ROW_TRADES, 5'd31, 16'h0000,  1'b0, 1'b0, 32'd0},
    '{ROW_PRICE,  5'd0,  16'h0000,  1'b0, 1'b0, 32'd0},
    '{ROW_PRICE,  5'd0,  16'hFFFF,  1'b0, 1'b0, 32'd0},
    '{ROW_TRADES, 5'd16, 16'h0000,  1'b0, 1'b0, 32'd0},
    '{ROW_PRICE,  5'd0,  16'h5555,  1'b1, 1'b1, 32'd0},
    '{ROW_PRICE,  5'd0,  16'hAAAA,  1'b0, 1'b0, 32'd0},
    '{ROW_PRICE,  5'd0,  16'h8000,  1'b0, 1'b0, 32'd0},
    '{ROW_PRICE,  5'd0,  16'h0001,  1'b0, 1'b0, 32'd0},
    '{ROW_PRICE,  5'd0,  16'hFFFE,  1'b0, 1'b0, 32'd0},
    '{ROW_PRICE,  5'd0,  16'h7FFF,  1'b0, 1'b0, 32'd0},
    '{ROW_TRADES, 5'd1,  16'h0000,  1'b0, 1'b0, 32'd0},
    '{ROW_PRICE,  5'd0,  16'hFFFF,  1'b0, 1'b0, 32'd0},
    '{ROW_PRICE,  5'd0,  16'h0000,  1'b0, 1'b0, 32'd0},
    '{ROW_PRICE,  5'd0,  16'h0000,  1'b1, 1'b1, 32'd0},
    '{ROW_PRICE,  5'd0,  16'h0000,  1'b0, 1'b0, 32'd0},
    '{ROW_PRICE,  5'd0,  16'h0000,  1'b0, 1'b0, 32'd0}
  };

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic profit_word_t advance_trade_tables(input logic [PRICE_W-1:0] price,
                                                        input logic first);
    profit_word_t word;
    longint       diff;
    longint       gain;
    longint       fresh;
    longint       carry;
    longint       pick;
    int           sel;
    if (first) begin
      for (int j = 0; j <= MAX_TRADES; j++) begin
        overall_best[j] = '0;
        ending_best[j]  = '0;
      end
      clamp_flag      = 1'b0;
      last_seen_price = price;
      word            = '0;
      return word;
    end
    diff = longint'(price) - longint'(last_seen_price);
    gain = (diff > 0) ? diff : 0;
    // walk down so each count reads the old best of the count below
    for (int j = MAX_TRADES; j >= 1; j--) begin
      fresh = longint'(overall_best[j-1]) + gain;
      carry = longint'(ending_best[j]) + diff;
      pick  = (fresh > carry) ? fresh : carry;
      if (pick > PROFIT_TOP) begin
        pick       = PROFIT_TOP;
        clamp_flag = 1'b1;
      end
      ending_best[j] = pick[PROFIT_W-1:0];
      if (ending_best[j] > overall_best[j])
        overall_best[j] = ending_best[j];
    end
    last_seen_price = price;
    sel = (int'(trades_setting) > MAX_TRADES) ? MAX_TRADES : int'(trades_setting);
    word.best_profit = overall_best[sel];
    word.saturated   = clamp_flag;
    return word;
  endfunction

  task automatic send_price(input logic [PRICE_W-1:0] price, input logic first,
                            input logic typed, input logic [PROFIT_W-1:0] typed_profit);
    profit_word_t predicted;
    int           gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 6);
      repeat (gap) begin
        @(negedge clk);
        prices.valid <= 1'b0;
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    @(negedge clk);
    prices.valid <= 1'b1;
    prices.price <= price;
    prices.first <= first;
    forever begin
      @(posedge clk);
      if (prices.ready) break;
    end
    predicted = advance_trade_tables(price, first);
    if (typed) predicted = '{typed_profit, 1'b0};
    expected_profits.push_back(predicted);
  endtask

  task automatic write_trades(input logic [TRADES_W-1:0] value);
    @(negedge clk);
    prices.valid <= 1'b0;
    while (expected_profits.size() != 0) @(negedge clk);
    cfg_we         <= 1'b1;
    cfg_data       <= value;
    trades_setting = value;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode = stall_mode_t'($urandom_range(0, 2));
      stall_left = $urandom_range(16, 80);
    end
    stall_left--;
    case (stall_mode)
      READY_ALWAYS: profits.ready <= 1'b1;
      READY_HALF:   profits.ready <= ($urandom_range(0, 1) == 1);
      default:      profits.ready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  always @(posedge clk) begin : check_profit
    profit_word_t want;
    if (!rst && profits.valid && profits.ready) begin
      if (expected_profits.size() == 0) begin
        $error("unexpected profit word: best_profit %0d", profits.best_profit);
        mismatches++;
      end else begin
        want = expected_profits.pop_front();
        if (profits.best_profit !== want.best_profit) begin
          $error("best_profit: expected %0d, actual %0d", want.best_profit,
                 profits.best_profit);
          mismatches++;
        end
        if (profits.saturated !== want.saturated) begin
          $error("saturated: expected %0b, actual %0b", want.saturated, profits.saturated);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    int           last_price;
    int           step;
    logic         f;
    price_style_t style;
    rst           = 1'b1;
    cfg_we        = 1'b0;
    cfg_data      = '0;
    prices.valid  = 1'b0;
    prices.price  = '0;
    prices.first  = 1'b0;
    profits.ready = 1'b0;
    last_price    = 0;
    style         = ANY_PRICE;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_TRADES)
        write_trades(directed_rows[i].trades);
      else
        send_price(directed_rows[i].price, directed_rows[i].first,
                   directed_rows[i].typed, directed_rows[i].profit);
    end

    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0:       write_trades(5'd16);
        1:       write_trades(5'd0);
        2:       write_trades(5'd31);
        3:       write_trades(5'd1);
        default: write_trades(TRADES_W'($urandom_range(0, 31)));
      endcase
      for (int n = 0; n < PHASE_WORDS; n++) begin
        f = ($urandom_range(0, 99) < 3);
        if (f) style = price_style_t'($urandom_range(0, 3));
        case (style)
          WALK_SMALL: begin
            step       = int'($urandom_range(0, 600)) - 300;
            last_price = last_price + step;
            if (last_price < 0) last_price = 0;
            if (last_price > 65535) last_price = 65535;
          end
          SWING_EXTREME: begin
            if (last_price < 32768) last_price = 65535 - int'($urandom_range(0, 3));
            else last_price = $urandom_range(0, 3);
          end
          ANY_PRICE: last_price = $urandom_range(0, 65535);
          default: begin
            if ($urandom_range(0, 1) == 1) last_price = $urandom_range(65280, 65535);
            else last_price = $urandom_range(0, 255);
          end
        endcase
        send_price(last_price[PRICE_W-1:0], f, 1'b0, '0);
      end
    end

    @(negedge clk);
    prices.valid <= 1'b0;
    while (expected_profits.size() != 0) @(negedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

// ----- sim.f -----
hw/rtl/mktdp_pkg.sv
hw/rtl/mktdp_if.sv
hw/rtl/mktdp_cell.sv
hw/rtl/max_profit_k_trades_dp.sv
hw/rtl/mktdp_check.sv
tb/max_profit_k_trades_dp_tb.sv
